// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MED_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// When pre holds, post must hold at the next clock edge.
`define MED_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/med_pkg.sv =====
// ---------------------------------------------------------------------------
// Motion delta encoder package
// Record types, kind codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package med_pkg;

    localparam int unsigned IN_DATA_W  = 160;
    localparam int unsigned IN_USER_W  = 1;
    localparam int unsigned OUT_DATA_W = 144;
    localparam int unsigned OUT_USER_W = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Record kinds
    localparam logic [2:0] KIND_VEL     = 3'd0;
    localparam logic [2:0] KIND_TP      = 3'd1;
    localparam logic [2:0] KIND_MOVEROT = 3'd2;
    localparam logic [2:0] KIND_MOVE    = 3'd3;
    localparam logic [2:0] KIND_ROT     = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_UPDATE_PERIOD    = 3'd0;
    localparam logic [2:0] REG_KEYFRAME_PERIOD  = 3'd1;
    localparam logic [2:0] REG_VELOCITY_ENABLE  = 3'd2;
    localparam logic [2:0] REG_MOTION_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_ENTITY_NUMBER    = 3'd4;

    // Register reset values
    localparam logic [7:0]  RST_UPDATE_PERIOD   = 8'd3;
    localparam logic [15:0] RST_KEYFRAME_PERIOD = 16'd400;
    localparam logic        RST_VELOCITY_ENABLE = 1'b1;
    localparam logic [29:0] RST_THRESHOLD_SQ    = 30'd25600;   // 160 squared
    localparam logic [30:0] RST_ENTITY_NUMBER   = 31'd0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] val_x;
        logic [31:0] val_y;
        logic [31:0] val_z;
        logic [7:0]  yaw;
        logic [7:0]  pitch;
        logic        to_self;
    } med_rec_t;

    // Records of one tick, compacted from slot 0 up
    typedef struct packed {
        logic               valid;
        logic [1:0]         count;
        med_rec_t [2:0]     recs;
    } med_load_t;

endpackage

// ===== hdl/med_rec_queue.sv =====
// ---------------------------------------------------------------------------
// Record queue
// Holds a tick's up to three records; sends one a cycle while m_ready is high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module med_rec_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  med_pkg::med_load_t load,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output med_pkg::med_rec_t  m_rec,
    output logic               m_last
);
    import med_pkg::*;

    med_rec_t   rec_reg [3];
    logic [1:0] rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       take;

    assign m_valid = (cnt_reg != 2'd0);
    assign m_last  = (cnt_reg == 2'd1);
    assign take    = m_valid && m_ready;
    assign free    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);

    always_comb begin
        case (rd_reg)
            2'd0:    m_rec = rec_reg[0];
            2'd1:    m_rec = rec_reg[1];
            2'd2:    m_rec = rec_reg[2];
            default: m_rec = '0;
        endcase
    end

    always_comb begin
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (load.valid) begin
            rd_next  = 2'd0;
            cnt_next = load.count;
        end else if (take) begin
            rd_next  = rd_reg + 2'd1;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= 2'd0;
            cnt_reg <= 2'd0;
        end else begin
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load.valid) begin
            for (int i = 0; i < 3; i++) begin
                rec_reg[i] <= load.recs[i];
            end
        end
    end

    `MED_ASSERT_CLK(a_head_in_range, ({1'b0, rd_reg} + {1'b0, cnt_reg}) <= 3'd3, "queue head past end")
    `MED_ASSERT_CLK(a_load_only_free, !load.valid || free, "queue loaded while busy")
    `MED_ASSERT_NEXT(a_empty_load, load.valid && (load.count == 2'd0), !m_valid, "empty load shows a beat")

endmodule

// ===== hdl/entity_motion_delta_encoder.sv =====
// ---------------------------------------------------------------------------
// Entity motion delta encoder
// A tick's records pass the input register, then the record queue, to m_.
// Throughput: one tick per cycle while the queue is free; one beat per record.
// The single record output port sets the rate: up to three beats per tick.
// Reset (aresetn low, synchronous): registers to defaults, state and queue cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module entity_motion_delta_encoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input ticks
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, yaw_q, pitch_q
    input  logic [med_pkg::IN_DATA_W-1:0]     s_tdata,
    // force_velocity
    input  logic [med_pkg::IN_USER_W-1:0]     s_tuser,
    // records
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // val_x, val_y, val_z, yaw_out, pitch_out, ident, zero pad bit
    output logic [med_pkg::OUT_DATA_W-1:0]    m_tdata,
    // kind, to_self
    output logic [med_pkg::OUT_USER_W-1:0]    m_tuser,
    output logic                              m_tlast,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [med_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [med_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import med_pkg::*;

    // Configuration registers; the threshold is kept squared, computed on write
    logic [7:0]  upd_period_reg;
    logic [15:0] kf_period_reg;
    logic        vel_en_reg;
    logic [29:0] th_sq_reg;
    logic [30:0] ent_reg;
    logic [29:0] th_sq_next;

    // Encoder state
    logic signed [15:0] sent_vel_reg [3];
    logic signed [31:0] sent_pos_reg [3];
    logic [7:0]         sent_yaw_reg, sent_pitch_reg;
    logic [7:0]         tick_reg, tick_next;
    logic [15:0]        kf_reg, kf_next;

    // Input register
    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic                 in_force_reg;

    logic signed [15:0] vel [3];
    logic signed [31:0] pos [3];
    logic [7:0]         yaw, pitch;

    logic               advance, q_free;
    med_load_t          load;
    med_rec_t           q_rec;

    // Tick decision
    logic [7:0]         tick_inc;
    logic [15:0]        kf_inc;
    logic               kf_due, check;
    logic signed [15:0] vel_base [3];
    logic signed [16:0] dv [3];
    logic signed [33:0] sq [3];
    logic [34:0]        sq_sum;
    logic               vel_change, stopped, vel_rec;
    logic signed [32:0] d [3];
    logic               far, tp, moved, turned, pos_rec;
    med_rec_t           rec_force, rec_vel, rec_pos;

    assign cfg_ready = 1'b1;
    assign s_tready  = !in_valid_reg || advance;
    assign advance   = in_valid_reg && q_free;

    // Unpack the held beat
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vel[i] = in_data_reg[16*i +: 16];
            pos[i] = in_data_reg[48 + 32*i +: 32];
        end
        yaw   = in_data_reg[151:144];
        pitch = in_data_reg[159:152];
    end

    // Counters advance first, both saturating
    assign tick_inc = (tick_reg == 8'hFF) ? tick_reg : tick_reg + 8'd1;
    assign kf_inc   = (kf_reg == 16'hFFFF) ? kf_reg : kf_reg + 16'd1;
    assign kf_due   = (kf_inc >= kf_period_reg);
    assign check    = (tick_inc >= upd_period_reg) || kf_due;

    // Velocity check: squared change against squared threshold. A forced
    // record this tick has already moved the baseline to the new velocity.
    always_comb begin
        vel_change = 1'b0;
        stopped    = 1'b1;
        for (int i = 0; i < 3; i++) begin
            vel_base[i] = in_force_reg ? vel[i] : sent_vel_reg[i];
            dv[i]       = 17'(vel[i]) - 17'(vel_base[i]);
            sq[i]       = 34'(dv[i]) * 34'(dv[i]);
            if (dv[i] != 17'sd0) vel_change = 1'b1;
            if (vel[i] != 16'sd0) stopped = 1'b0;
        end
        sq_sum  = {2'b00, sq[0][32:0]} + {2'b00, sq[1][32:0]} + {2'b00, sq[2][32:0]};
        vel_rec = check && vel_en_reg
                  && ((sq_sum > {5'd0, th_sq_reg}) || (vel_change && stopped));
    end

    // Position check: wide deltas, teleport when any leaves -128..127 or a keyframe is due
    always_comb begin
        far   = 1'b0;
        moved = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d[i] = 33'(pos[i]) - 33'(sent_pos_reg[i]);
            if (!((d[i][32:7] == '0) || (d[i][32:7] == '1))) far = 1'b1;
            if (d[i] != 33'sd0) moved = 1'b1;
        end
        turned  = (yaw != sent_yaw_reg) || (pitch != sent_pitch_reg);
        tp      = check && (far || kf_due);
        pos_rec = check && (tp || moved || turned);
    end

    // Build candidate records
    always_comb begin
        rec_force.kind    = KIND_VEL;
        rec_force.val_x   = 32'(vel[0]);
        rec_force.val_y   = 32'(vel[1]);
        rec_force.val_z   = 32'(vel[2]);
        rec_force.yaw     = 8'd0;
        rec_force.pitch   = 8'd0;
        rec_force.to_self = 1'b1;

        rec_vel         = rec_force;
        rec_vel.to_self = 1'b0;

        rec_pos.to_self = 1'b0;
        if (tp) begin
            rec_pos.kind  = KIND_TP;
            rec_pos.val_x = pos[0];
            rec_pos.val_y = pos[1];
            rec_pos.val_z = pos[2];
            rec_pos.yaw   = yaw;
            rec_pos.pitch = pitch;
        end else if (moved) begin
            rec_pos.kind  = turned ? KIND_MOVEROT : KIND_MOVE;
            rec_pos.val_x = d[0][31:0];
            rec_pos.val_y = d[1][31:0];
            rec_pos.val_z = d[2][31:0];
            rec_pos.yaw   = turned ? yaw : 8'd0;
            rec_pos.pitch = turned ? pitch : 8'd0;
        end else begin
            rec_pos.kind  = KIND_ROT;
            rec_pos.val_x = 32'd0;
            rec_pos.val_y = 32'd0;
            rec_pos.val_z = 32'd0;
            rec_pos.yaw   = yaw;
            rec_pos.pitch = pitch;
        end
    end

    // Compact present records into slots from 0 up
    always_comb begin
        load.valid   = advance;
        load.count   = {1'b0, in_force_reg} + {1'b0, vel_rec} + {1'b0, pos_rec};
        load.recs[2] = rec_pos;
        load.recs[1] = in_force_reg ? (vel_rec ? rec_vel : rec_pos) : rec_pos;
        load.recs[0] = in_force_reg ? rec_force : (vel_rec ? rec_vel : rec_pos);
    end

    // Next counter values: a check clears the tick count, a teleport the keyframe count
    assign tick_next  = check ? 8'd0 : tick_inc;
    assign kf_next    = tp ? 16'd0 : kf_inc;
    assign th_sq_next = 30'(cfg_data[14:0]) * 30'(cfg_data[14:0]);

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            upd_period_reg <= RST_UPDATE_PERIOD;
            kf_period_reg  <= RST_KEYFRAME_PERIOD;
            vel_en_reg     <= RST_VELOCITY_ENABLE;
            th_sq_reg      <= RST_THRESHOLD_SQ;
            ent_reg        <= RST_ENTITY_NUMBER;
            for (int i = 0; i < 3; i++) begin
                sent_vel_reg[i] <= 16'sd0;
                sent_pos_reg[i] <= 32'sd0;
            end
            sent_yaw_reg   <= 8'd0;
            sent_pitch_reg <= 8'd0;
            tick_reg       <= 8'd0;
            kf_reg         <= 16'd0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_UPDATE_PERIOD:    upd_period_reg <= cfg_data[7:0];
                    REG_KEYFRAME_PERIOD:  kf_period_reg  <= cfg_data[15:0];
                    REG_VELOCITY_ENABLE:  vel_en_reg     <= cfg_data[0];
                    REG_MOTION_THRESHOLD: th_sq_reg      <= th_sq_next;
                    REG_ENTITY_NUMBER:    ent_reg        <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (advance) begin
                tick_reg <= tick_next;
                kf_reg   <= kf_next;
                // Either velocity record moves the baseline to the new velocity
                if (in_force_reg || vel_rec) begin
                    for (int i = 0; i < 3; i++) begin
                        sent_vel_reg[i] <= vel[i];
                    end
                end
                if (tp || (check && moved)) begin
                    for (int i = 0; i < 3; i++) begin
                        sent_pos_reg[i] <= pos[i];
                    end
                end
                if (tp || (check && turned)) begin
                    sent_yaw_reg   <= yaw;
                    sent_pitch_reg <= pitch;
                end
            end
        end
    end

    // Hold the payload of an accepted beat
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg  <= s_tdata;
            in_force_reg <= s_tuser[0];
        end
    end

    med_rec_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .free    (q_free),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_rec   (q_rec),
        .m_last  (m_tlast)
    );

    // Pack the outgoing beat; ident comes straight from its register
    assign m_tdata = {1'b0, ent_reg, q_rec.pitch, q_rec.yaw,
                      q_rec.val_z, q_rec.val_y, q_rec.val_x};
    assign m_tuser = {q_rec.to_self, q_rec.kind};

    `MED_ASSERT_NEXT(a_hold_tick, in_valid_reg && !advance, in_valid_reg, "held tick dropped")
    `MED_ASSERT_NEXT(a_check_clears, advance && check, tick_reg == 8'd0, "check left tick count")
    `MED_ASSERT_NEXT(a_tp_clears_kf, advance && tp, kf_reg == 16'd0, "teleport left keyframe count")

endmodule

// ===== dv/med_record_checker.sv =====
// ---------------------------------------------------------------------------
// Motion delta encoder record checker
// Snoops the tick, record and register channels, predicts the records of
// each accepted tick and compares every record beat field by field.
// ---------------------------------------------------------------------------
module med_record_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [med_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [med_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [med_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [med_pkg::OUT_USER_W-1:0] m_tuser,
    input  logic                           m_tlast,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [med_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [med_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             error_count,
    output int                             records_due
);
    import med_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] val_x;
        logic [31:0] val_y;
        logic [31:0] val_z;
        logic [7:0]  yaw;
        logic [7:0]  pitch;
        logic [30:0] ident;
        logic        to_self;
        logic        last;
    } motion_rec_t;

    motion_rec_t        due_records [$];

    // register mirror
    logic [7:0]         upd_period;
    logic [15:0]        kf_period;
    logic               vel_enable;
    logic [14:0]        vel_threshold;
    logic [30:0]        entity_id;

    // what the far end last heard
    logic signed [15:0] sent_vel [3];
    logic signed [31:0] sent_pos [3];
    logic [7:0]         sent_yaw;
    logic [7:0]         sent_pitch;
    logic [7:0]         tick_cnt;
    logic [15:0]        kf_cnt;

    initial begin
        error_count = 0;
        records_due = 0;
    end

    task automatic push_record(input logic [2:0] kind, input logic signed [31:0] x,
                               input logic signed [31:0] y, input logic signed [31:0] z,
                               input logic [7:0] yaw, input logic [7:0] pitch,
                               input logic to_self);
        motion_rec_t r;
        r.kind    = kind;
        r.val_x   = x;
        r.val_y   = y;
        r.val_z   = z;
        r.yaw     = yaw;
        r.pitch   = pitch;
        r.ident   = entity_id;
        r.to_self = to_self;
        r.last    = 1'b0;
        due_records = {due_records, r};
    endtask

    task automatic encode_tick(input logic forced, input logic [IN_DATA_W-1:0] d);
        logic signed [15:0] vel [3];
        logic signed [31:0] pos [3];
        logic [7:0]         yaw;
        logic [7:0]         pitch;
        longint             dpos [3];
        longint             dv;
        longint             sq;
        longint             th;
        bit                 kf_due;
        bit                 far_off;
        bit                 moved;
        bit                 turned;
        int                 n;
        motion_rec_t        r;
        for (int k = 0; k < 3; k++) begin
            vel[k] = d[16*k +: 16];
            pos[k] = d[48 + 32*k +: 32];
        end
        yaw   = d[151:144];
        pitch = d[159:152];
        n     = 0;

        // forced record goes out first, flagged for the entity itself
        if (forced) begin
            for (int k = 0; k < 3; k++) sent_vel[k] = vel[k];
            push_record(KIND_VEL, 32'(vel[0]), 32'(vel[1]), 32'(vel[2]),
                        8'd0, 8'd0, 1'b1);
            n++;
        end

        if (kf_cnt != 16'hFFFF) kf_cnt++;
        if (tick_cnt != 8'hFF) tick_cnt++;
        kf_due = kf_cnt >= kf_period;

        if (tick_cnt >= upd_period || kf_due) begin
            tick_cnt = 8'd0;
            if (vel_enable) begin
                sq = 0;
                th = longint'(vel_threshold) * longint'(vel_threshold);
                for (int k = 0; k < 3; k++) begin
                    dv = longint'(vel[k]) - longint'(sent_vel[k]);
                    sq += dv * dv;
                end
                // a stop is always reported, whatever the threshold
                if (sq > th || (sq > 0 && vel[0] == 0 && vel[1] == 0 && vel[2] == 0)) begin
                    for (int k = 0; k < 3; k++) sent_vel[k] = vel[k];
                    push_record(KIND_VEL, 32'(vel[0]), 32'(vel[1]), 32'(vel[2]),
                                8'd0, 8'd0, 1'b0);
                    n++;
                end
            end

            far_off = 1'b0;
            for (int k = 0; k < 3; k++) begin
                dpos[k] = longint'(pos[k]) - longint'(sent_pos[k]);
                if (dpos[k] < -128 || dpos[k] > 127) far_off = 1'b1;
            end

            if (far_off || kf_due) begin
                kf_cnt = 16'd0;
                push_record(KIND_TP, pos[0], pos[1], pos[2], yaw, pitch, 1'b0);
                n++;
                for (int k = 0; k < 3; k++) sent_pos[k] = pos[k];
                sent_yaw   = yaw;
                sent_pitch = pitch;
            end else begin
                moved  = dpos[0] != 0 || dpos[1] != 0 || dpos[2] != 0;
                turned = yaw != sent_yaw || pitch != sent_pitch;
                if (moved) begin
                    push_record(turned ? KIND_MOVEROT : KIND_MOVE, 32'(dpos[0]),
                                32'(dpos[1]), 32'(dpos[2]),
                                turned ? yaw : 8'd0, turned ? pitch : 8'd0, 1'b0);
                    n++;
                    for (int k = 0; k < 3; k++) sent_pos[k] = pos[k];
                end else if (turned) begin
                    push_record(KIND_ROT, 32'sd0, 32'sd0, 32'sd0, yaw, pitch, 1'b0);
                    n++;
                end
                if (turned) begin
                    sent_yaw   = yaw;
                    sent_pitch = pitch;
                end
            end
        end

        if (n > 0) begin
            r = due_records.pop_back();
            r.last = 1'b1;
            due_records = {due_records, r};
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        motion_rec_t want;
        if (!aresetn) begin
            upd_period    = RST_UPDATE_PERIOD;
            kf_period     = RST_KEYFRAME_PERIOD;
            vel_enable    = RST_VELOCITY_ENABLE;
            vel_threshold = 15'd160;
            entity_id     = RST_ENTITY_NUMBER;
            for (int k = 0; k < 3; k++) begin
                sent_vel[k] = '0;
                sent_pos[k] = '0;
            end
            sent_yaw   = '0;
            sent_pitch = '0;
            tick_cnt   = '0;
            kf_cnt     = '0;
            due_records.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_UPDATE_PERIOD:    upd_period    = cfg_data[7:0];
                    REG_KEYFRAME_PERIOD:  kf_period     = cfg_data[15:0];
                    REG_VELOCITY_ENABLE:  vel_enable    = cfg_data[0];
                    REG_MOTION_THRESHOLD: vel_threshold = cfg_data[14:0];
                    REG_ENTITY_NUMBER:    entity_id     = cfg_data[30:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                if (due_records.size() == 0) begin
                    $display("%0t: unexpected record, expected none, actual kind %0d",
                             $time, m_tuser[2:0]);
                    error_count++;
                end else begin
                    want = due_records.pop_front();
                    check_field("kind",    32'(want.kind),    32'(m_tuser[2:0]));
                    check_field("val_x",   want.val_x,        m_tdata[31:0]);
                    check_field("val_y",   want.val_y,        m_tdata[63:32]);
                    check_field("val_z",   want.val_z,        m_tdata[95:64]);
                    check_field("yaw",     32'(want.yaw),     32'(m_tdata[103:96]));
                    check_field("pitch",   32'(want.pitch),   32'(m_tdata[111:104]));
                    check_field("ident",   32'(want.ident),   32'(m_tdata[142:112]));
                    check_field("to_self", 32'(want.to_self), 32'(m_tuser[3]));
                    check_field("last",    32'(want.last),    32'(m_tlast));
                end
            end

            if (s_tvalid && s_tready) encode_tick(s_tuser[0], s_tdata);
        end
        records_due = due_records.size();
    end

endmodule

// ===== dv/entity_motion_delta_encoder_tb.sv =====
// ---------------------------------------------------------------------------
// Motion delta encoder testbench
// Drives entity ticks and register writes into the encoder, with random
// gaps on the tick side and random back-pressure on the record side, and
// leaves prediction and comparison to the record checker beside it.
// ---------------------------------------------------------------------------
module entity_motion_delta_encoder_tb;
    import med_pkg::*;

    // Generous cap: ~500 ticks, three records each, long stalls on both sides.
    localparam int CYCLE_LIMIT = 600000;
    // Cycles to sit out after the last record, covering ticks with no record.
    localparam int SETTLE_CYCLES = 8;
    // Length of the one long receiver hold-off.
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        int upd;
        int kf;
        int ven;
        int thr;
        int ent;
        int ticks;
    } phase_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                    error_count;
    int                    records_due;
    int                    cycle_count = 0;

    // Receiver pacing state
    bit                    hold_req = 1'b0;
    bit                    rx_hold = 1'b0;
    bit                    rdy_want = 1'b0;
    int                    rdy_left = 0;

    // Current entity state the random walk moves from
    logic [15:0]           cur_vel [3];
    logic [31:0]           cur_pos [3];
    logic [7:0]            cur_yaw;
    logic [7:0]            cur_pitch;

    entity_motion_delta_encoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    med_record_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .records_due (records_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Record-side pacing: random stretches of ready and stall, mostly short.
    // The long hold-off overrides everything while it runs.
    always @(posedge aclk) begin
        int r;
        if (rdy_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                rdy_want = 1'b1;
                rdy_left = $urandom_range(1, 24);
            end else if (r < 85) begin
                rdy_want = 1'b0;
                rdy_left = $urandom_range(1, 3);
            end else if (r < 97) begin
                rdy_want = 1'b0;
                rdy_left = $urandom_range(4, 12);
            end else begin
                rdy_want = 1'b0;
                rdy_left = $urandom_range(20, 60);
            end
        end else begin
            rdy_left = rdy_left - 1;
        end
        m_tready <= rdy_want && !rx_hold && aresetn;
    end

    // One long receiver hold-off, counted here while the ticks keep coming,
    // so the encoder backs up and drops s_tready.
    initial begin : rx_long_hold
        wait (hold_req);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Gap after a tick beat: mostly none, sometimes a few, rarely a long one.
    function automatic int tick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer the current entity state as one tick beat; hold tvalid high
    // across back-to-back beats and drop it only for a gap.
    task automatic send_tick(input logic forced);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= forced;
        s_tdata  <= {cur_pitch, cur_yaw, cur_pos[2], cur_pos[1], cur_pos[0],
                     cur_vel[2], cur_vel[1], cur_vel[0]};
        do @(posedge aclk); while (!s_tready);
        gap = tick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic put_tick(input logic forced,
                            input logic [15:0] vx, input logic [15:0] vy,
                            input logic [15:0] vz, input logic [31:0] px,
                            input logic [31:0] py, input logic [31:0] pz,
                            input logic [7:0] yaw, input logic [7:0] pitch);
        cur_vel[0] = vx;
        cur_vel[1] = vy;
        cur_vel[2] = vz;
        cur_pos[0] = px;
        cur_pos[1] = py;
        cur_pos[2] = pz;
        cur_yaw    = yaw;
        cur_pitch  = pitch;
        send_tick(forced);
    endtask

    // Mostly a plausible walk: small steps, deltas near the move/teleport
    // boundary, the odd jump, stops and velocity swings. The rest is noise.
    task automatic random_tick();
        int   r;
        int   rs;
        logic forced;
        r      = $urandom_range(0, 99);
        forced = ($urandom_range(0, 9) == 0);
        if (r >= 90) begin
            for (int k = 0; k < 3; k++) begin
                cur_vel[k] = 16'($urandom);
                cur_pos[k] = $urandom;
            end
            cur_yaw   = 8'($urandom);
            cur_pitch = 8'($urandom);
            forced    = ($urandom_range(0, 1) == 1);
        end else begin
            for (int k = 0; k < 3; k++) begin
                rs = $urandom_range(0, 99);
                if (rs < 55)      cur_pos[k] = cur_pos[k] + $urandom_range(0, 8) - 4;
                else if (rs < 85) cur_pos[k] = cur_pos[k];
                else if (rs < 97) cur_pos[k] = cur_pos[k] + $urandom_range(0, 260) - 130;
                else              cur_pos[k] = $urandom;
            end
            rs = $urandom_range(0, 99);
            for (int k = 0; k < 3; k++) begin
                if (rs < 15)      cur_vel[k] = '0;
                else if (rs < 55) cur_vel[k] = cur_vel[k];
                else if (rs < 90) cur_vel[k] = 16'(cur_vel[k] + $urandom_range(0, 600) - 300);
                else              cur_vel[k] = 16'($urandom);
            end
            rs = $urandom_range(0, 99);
            if (rs < 20) begin
                cur_yaw   = 8'(cur_yaw + $urandom_range(0, 6) - 3);
                cur_pitch = 8'(cur_pitch + $urandom_range(0, 6) - 3);
            end else if (rs < 30) begin
                cur_yaw   = 8'($urandom);
                cur_pitch = 8'($urandom);
            end
        end
        send_tick(forced);
    endtask

    // Register writes: keep cfg_valid high across the whole burst.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 32'(value);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_regs(input int upd, input int kf, input int ven,
                                input int thr, input int ent);
        write_reg(REG_UPDATE_PERIOD, upd);
        write_reg(REG_KEYFRAME_PERIOD, kf);
        write_reg(REG_VELOCITY_ENABLE, ven);
        write_reg(REG_MOTION_THRESHOLD, thr);
        write_reg(REG_ENTITY_NUMBER, ent);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering ticks and wait until every predicted record is out,
    // then give the pipe time to finish ticks that produce nothing.
    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (records_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        phase_t plan [5];

        for (int k = 0; k < 3; k++) begin
            cur_vel[k] = '0;
            cur_pos[k] = '0;
        end
        cur_yaw   = '0;
        cur_pitch = '0;

        plan[0] = '{3, 400, 1, 160, 1234, 60};
        plan[1] = '{1, 7, 1, 0, 32'h7FFFFFFF, 80};       // long hold-off here
        plan[2] = '{255, 65535, 1, 32767, 0, 260};       // sparse checks
        plan[3] = '{0, 1, 0, 50, 0, 40};
        plan[4] = '{9, 4, 1, 0, 0, 50};                  // keyframe drives checks
        plan[3].ent = $urandom & 32'h7FFFFFFF;
        plan[4].thr = $urandom_range(1, 2000);
        plan[4].ent = $urandom & 32'h7FFFFFFF;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: check on every tick so each beat shows its own outcome.
        program_regs(1, 400, 1, 160, 32'h00000ABC);
        put_tick(0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h00);                  // quiet tick
        put_tick(0, 0, 0, 0, 5, -3, 1, 8'h00, 8'h00);                 // move only
        put_tick(0, 0, 0, 0, 5, -3, 1, 8'h80, 8'hFF);                 // rotate only
        put_tick(0, 0, 0, 0, 132, -131, 1, 8'h01, 8'h7F);             // move+rotate, edge deltas
        put_tick(0, 0, 0, 0, 260, -131, 1, 8'h01, 8'h7F);             // delta 128: teleport
        put_tick(0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 260, -131, 1, 8'h01, 8'h7F);
        put_tick(1, 16'h8000, 16'h8000, 16'h8000, 260, -131, 1, 8'h01, 8'h7F);
        put_tick(0, 0, 0, 0, 260, -131, 1, 8'h01, 8'h7F);             // stop
        put_tick(0, 100, 0, 0, 260, -131, 1, 8'h01, 8'h7F);           // under threshold
        put_tick(0, 100, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 8'hFF, 8'h00);
        put_tick(0, 100, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 8'h00, 8'hFF);
        put_tick(1, 1, 16'hFFFF, 0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 8'h00, 8'hFF);
        drain();

        // Directed: zero periods, velocity records off, widest entity number.
        program_regs(0, 0, 0, 0, 32'h7FFFFFFF);
        put_tick(0, 123, 0, 0, 0, 0, 0, 8'h55, 8'h55);
        put_tick(1, -5, 7, 0, -1, -1, -1, 8'hAA, 8'hAA);
        put_tick(0, 0, 0, 0, -1, -1, -1, 8'hAA, 8'hAA);
        drain();

        // Random phases, each under its own register setting.
        for (int p = 0; p < 5; p++) begin
            program_regs(plan[p].upd, plan[p].kf, plan[p].ven, plan[p].thr, plan[p].ent);
            if (p == 1) hold_req <= 1'b1;
            for (int i = 0; i < plan[p].ticks; i++) random_tick();
            drain();
        end

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
